### hdl/adrfc_pkg.sv
// Shared types, codes and widths for the playback ring flow control block.
package adrfc_pkg;

  // Ring size default and fixed constants.
  localparam int unsigned RING_BYTES_DEFAULT = 131072;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned FRAME_MASK         = 3;

  // Field widths.
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned LEAD_W     = 16;
  localparam int unsigned COUNT_W    = 64;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ROFF_W     = 17;
  localparam int unsigned RLEN_W     = 18;
  localparam int unsigned SOFF_W     = 17;
  localparam int unsigned ANS_W      = 18;
  localparam int unsigned IN_DATA_W  = 2 * POS_W + LEN_W;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [LEAD_W-1:0] LEAD_RESET = 16'd4096;

  // Command codes on the input tuser.
  localparam logic [CMD_W-1:0] CMD_POLL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LAG   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd4;

  // Result kinds on the output tuser.
  localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COPY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINAL = 2'd2;

  // Decoded operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_POLL   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_LAG    = 3'd2,
    OP_OPEN   = 3'd3,
    OP_CLOSE  = 3'd4,
    OP_IGNORE = 3'd5
  } op_e;

  // One queued command.
  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] want;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROFF_W-1:0] ring_offset;
    logic [RLEN_W-1:0] range_length;
    logic [SOFF_W-1:0] source_offset;
    logic [ANS_W-1:0]  answer;
    logic              status;
    logic              last;
  } result_t;

endpackage

### hdl/audio_dma_ring_flow_control_top.sv
// Top level of the playback ring flow control block.
//
// Command beats enter on the s_axis channel; tuser holds the command code and
// tdata the DMA position word, the link position and the offered write length.
// Result beats leave on the m_axis channel; tuser holds the result kind and
// tlast marks the final answer, which closes every command. A write may give up
// to two zero-fill ranges and two copy ranges ahead of its answer.
// The cfg channel writes the lead distance in bytes; it is always ready.
// Commands pass through a two-entry queue into a sequencer that emits at most one
// beat per cycle. Open, close and rejected commands are answered in the head state,
// lag in the lag state, poll after the silence and zero-fill states, and write
// after those and the room and copy states. The first result passes through the
// queue and the output register. Reset clears the counts, closes the stream and
// sets the lead to 4096 bytes. When the receiver stalls, the output register holds
// its beat, the sequencer waits and the queue keeps taking commands until it is full.
module audio_dma_ring_flow_control_top #(
  parameter int unsigned RING_BYTES = adrfc_pkg::RING_BYTES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // dma_position [31:0], link_position [63:32], write_length [95:64]
  input  logic [adrfc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // command [2:0]
  input  logic [adrfc_pkg::CMD_W-1:0]      s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // ring_offset [16:0], range_length [34:17], source_offset [51:35],
  // answer [69:52], status [70], zero pad [71]
  output logic [adrfc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // kind [1:0]
  output logic [adrfc_pkg::KIND_W-1:0]     m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [adrfc_pkg::LEAD_W-1:0]     cfg_data_i
);
  import adrfc_pkg::*;

  logic    queue_full;
  logic    push_valid;
  entry_t  push_entry;
  logic    entry_valid;
  entry_t  entry;
  logic    pop;
  result_t result;

  assign cfg_ready_o = 1'b1;

  // Decode and enqueue.
  adrfc_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .queue_full_i    (queue_full),
    .push_valid_o    (push_valid),
    .push_entry_o    (push_entry)
  );

  adrfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .full_o       (queue_full),
    .pop_i        (pop),
    .valid_o      (entry_valid),
    .entry_o      (entry)
  );

  // Execute and emit.
  adrfc_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .lead_we_i     (cfg_valid_i),
    .lead_i        (cfg_data_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_o         (result)
  );

  // Pack the result beat.
  assign m_axis_tdata_o = {1'b0, result.status, result.answer, result.source_offset,
                           result.range_length, result.ring_offset};
  assign m_axis_tuser_o = result.kind;
  assign m_axis_tlast_o = result.last;

endmodule

### hdl/adrfc_front.sv
// Front end: accepts command beats, decodes the command and picks the play position.
module adrfc_front (
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [adrfc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [adrfc_pkg::CMD_W-1:0]      s_axis_tuser_i,
  input  logic                             queue_full_i,
  output logic                             push_valid_o,
  output adrfc_pkg::entry_t                push_entry_o
);
  import adrfc_pkg::*;

  logic [POS_W-1:0] dma_pos;
  logic [POS_W-1:0] link_pos;
  op_e              op;

  assign dma_pos  = s_axis_tdata_i[POS_W-1:0];
  assign link_pos = s_axis_tdata_i[2*POS_W-1:POS_W];

  // Command decoder; unknown codes become a no-op.
  always_comb begin
    unique case (s_axis_tuser_i)
      CMD_POLL:  op = OP_POLL;
      CMD_WRITE: op = OP_WRITE;
      CMD_LAG:   op = OP_LAG;
      CMD_OPEN:  op = OP_OPEN;
      CMD_CLOSE: op = OP_CLOSE;
      default:   op = OP_IGNORE;
    endcase
  end

  // A zero position word means the buffer was not written yet, so use the link position.
  assign push_entry_o.op   = op;
  assign push_entry_o.pos  = (dma_pos != '0) ? dma_pos : link_pos;
  assign push_entry_o.want = s_axis_tdata_i[2*POS_W+LEN_W-1:2*POS_W];

  assign s_axis_tready_o = !queue_full_i;
  assign push_valid_o    = s_axis_tvalid_i;

endmodule

### hdl/adrfc_queue.sv
// Short command queue between the front end and the back end.
module adrfc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  adrfc_pkg::entry_t push_entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output adrfc_pkg::entry_t entry_o
);
  import adrfc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q;
  logic [PTR_W-1:0] rptr_q;
  logic [PTR_W:0]   count_q;
  logic             push_fire;
  logic             pop_fire;

  assign full_o    = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign push_fire = push_valid_i && !full_o;
  assign pop_fire  = pop_i && valid_o;
  assign entry_o   = entries_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entries_q[wptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_fire) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (pop_fire) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      case ({push_fire, pop_fire})
        2'b10:   count_q <= count_q + (PTR_W+1)'(1);
        2'b01:   count_q <= count_q - (PTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/adrfc_back.sv
// Back end: runs each command against the running counts and emits result beats.
module adrfc_back #(
  parameter int unsigned RING_BYTES = adrfc_pkg::RING_BYTES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          entry_valid_i,
  input  adrfc_pkg::entry_t             entry_i,
  output logic                          pop_o,
  input  logic                          lead_we_i,
  input  logic [adrfc_pkg::LEAD_W-1:0]  lead_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output adrfc_pkg::result_t            out_o
);
  import adrfc_pkg::*;

  // The ring size is a power of two, so offsets are the low count bits.
  localparam int unsigned        RING_W     = $clog2(RING_BYTES);
  localparam logic [RING_W:0]    RING_LEN   = (RING_W+1)'(RING_BYTES);
  localparam logic [COUNT_W-1:0] RING_WIDE  = COUNT_W'(RING_BYTES);
  localparam logic [RING_W:0]    FRAME_KEEP = ~((RING_W+1)'(FRAME_MASK));

  typedef enum logic [5:0] {
    ST_HEAD = 6'b000001,
    ST_LAG  = 6'b000010,
    ST_SIL  = 6'b000100,
    ST_ZERO = 6'b001000,
    ST_ROOM = 6'b010000,
    ST_COPY = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [LEN_W-1:0]     want_q;
  logic [LEAD_W-1:0]    lead_q;
  logic [COUNT_W-1:0]   written_q;
  logic [COUNT_W-1:0]   played_q;
  logic [COUNT_W-1:0]   silenced_q;
  logic                 open_q;
  logic [RING_W:0]      dlen_q;
  logic [RING_W-1:0]    zoff_q;
  logic [COUNT_W-1:0]   queued_q;
  logic [RING_W:0]      nleft_q;
  logic [RING_W:0]      ntot_q;
  logic [RING_W:0]      src_q;
  logic                 out_valid_q;
  result_t              out_q;

  logic                 slot_free;
  logic                 emit_req;
  logic                 fire;
  result_t              emit_res;

  logic [RING_W-1:0]    pos_low;
  logic                 head_wrap;
  logic [COUNT_W-RING_W-1:0] played_hi;
  logic [COUNT_W-1:0]   head_next;
  logic [COUNT_W-1:0]   diff_wp;
  logic [ANS_W-1:0]     lag_frames;
  logic [COUNT_W-1:0]   sil_gap;
  logic [RING_W:0]      sil_len;
  logic [COUNT_W-1:0]   lead_wide;
  logic [COUNT_W-1:0]   lead_pos;
  logic [RING_W:0]      zero_room;
  logic [RING_W:0]      zero_n;
  logic [COUNT_W-1:0]   room_sum;
  logic [RING_W:0]      room;
  logic [RING_W:0]      take;
  logic [RING_W:0]      take_frames;
  logic [RING_W-1:0]    copy_off;
  logic [RING_W:0]      copy_room;
  logic [RING_W:0]      copy_n;

  function automatic result_t final_res(logic [ANS_W-1:0] ans, logic st);
    result_t r;
    r        = '0;
    r.kind   = KIND_FINAL;
    r.answer = ans;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic result_t range_res(logic [KIND_W-1:0] kind, logic [ROFF_W-1:0] roff,
                                        logic [RLEN_W-1:0] len, logic [SOFF_W-1:0] soff);
    result_t r;
    r               = '0;
    r.kind          = kind;
    r.ring_offset   = roff;
    r.range_length  = len;
    r.source_offset = soff;
    return r;
  endfunction

  // Unwrap the hardware position forward into the played count.
  assign pos_low   = entry_i.pos[RING_W-1:0];
  assign head_wrap = (pos_low < played_q[RING_W-1:0]);
  assign played_hi = played_q[COUNT_W-1:RING_W] + (COUNT_W-RING_W)'(head_wrap);
  assign head_next = {played_hi, pos_low};

  // Queued frames for the lag query.
  assign diff_wp    = written_q - played_q;
  assign lag_frames = (written_q > played_q) ? ANS_W'(diff_wp >> 2) : '0;

  // Silence span, capped at one ring.
  assign sil_gap = played_q - silenced_q;
  assign sil_len = (sil_gap > RING_WIDE) ? RING_LEN : sil_gap[RING_W:0];

  assign lead_wide = COUNT_W'(lead_q);
  assign lead_pos  = played_q + lead_wide;

  // Zero-fill range split at the ring end.
  assign zero_room = RING_LEN - {1'b0, zoff_q};
  assign zero_n    = (dlen_q < zero_room) ? dlen_q : zero_room;

  // Free room and the accepted byte count, whole frames only.
  assign room_sum    = queued_q + lead_wide;
  assign room        = (room_sum < RING_WIDE) ? (RING_LEN - room_sum[RING_W:0]) : '0;
  assign take        = (want_q < LEN_W'(room)) ? want_q[RING_W:0] : room;
  assign take_frames = take & FRAME_KEEP;

  // Copy range split at the ring end.
  assign copy_off  = written_q[RING_W-1:0];
  assign copy_room = RING_LEN - {1'b0, copy_off};
  assign copy_n    = (nleft_q < copy_room) ? nleft_q : copy_room;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = emit_req && slot_free;

  // Sequencer: one result beat per cycle at most.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    emit_req = 1'b0;
    emit_res = '0;
    unique case (state_q)
      ST_HEAD: begin
        if (entry_valid_i) begin
          unique case (entry_i.op) inside
            OP_OPEN, OP_IGNORE: begin
              emit_req = 1'b1;
              emit_res = final_res('0, 1'b0);
              pop_o    = slot_free;
            end
            OP_CLOSE: begin
              emit_req = 1'b1;
              emit_res = final_res('0, !open_q);
              pop_o    = slot_free;
            end
            OP_POLL, OP_WRITE, OP_LAG: begin
              if (!open_q) begin
                emit_req = 1'b1;
                emit_res = final_res('0, 1'b1);
                pop_o    = slot_free;
              end else begin
                pop_o   = 1'b1;
                state_d = (entry_i.op == OP_LAG) ? ST_LAG : ST_SIL;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      ST_LAG: begin
        emit_req = 1'b1;
        emit_res = final_res(lag_frames, 1'b0);
        if (slot_free) begin
          state_d = ST_HEAD;
        end
      end
      ST_SIL: state_d = ST_ZERO;
      ST_ZERO: begin
        if (dlen_q == '0) begin
          if (op_q == OP_POLL) begin
            emit_req = 1'b1;
            emit_res = final_res('0, 1'b0);
            if (slot_free) begin
              state_d = ST_HEAD;
            end
          end else begin
            state_d = ST_ROOM;
          end
        end else begin
          emit_req = 1'b1;
          emit_res = range_res(KIND_ZERO, ROFF_W'(zoff_q), RLEN_W'(zero_n), '0);
        end
      end
      ST_ROOM: state_d = ST_COPY;
      ST_COPY: begin
        if (nleft_q == '0) begin
          emit_req = 1'b1;
          emit_res = final_res(ANS_W'(ntot_q), 1'b0);
          if (slot_free) begin
            state_d = ST_HEAD;
          end
        end else begin
          emit_req = 1'b1;
          emit_res = range_res(KIND_COPY, ROFF_W'(copy_off), RLEN_W'(copy_n),
                               SOFF_W'(src_q));
        end
      end
      default: state_d = ST_HEAD;
    endcase
  end

  // Control state and running counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HEAD;
      out_valid_q <= 1'b0;
      lead_q      <= LEAD_RESET;
      written_q   <= '0;
      played_q    <= '0;
      silenced_q  <= '0;
      open_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (lead_we_i) begin
        lead_q <= lead_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_HEAD: begin
          if (entry_valid_i && pop_o) begin
            if (entry_i.op == OP_OPEN) begin
              written_q  <= '0;
              played_q   <= '0;
              silenced_q <= '0;
              open_q     <= 1'b1;
            end else if (entry_i.op == OP_CLOSE) begin
              open_q <= 1'b0;
            end else if (open_q && (entry_i.op == OP_POLL || entry_i.op == OP_WRITE ||
                                    entry_i.op == OP_LAG)) begin
              played_q <= head_next;
            end
          end
        end
        ST_SIL: begin
          silenced_q <= played_q;
          if (op_q == OP_WRITE && written_q < lead_pos) begin
            written_q <= lead_pos;
          end
        end
        ST_COPY: begin
          if (fire && nleft_q != '0) begin
            written_q <= written_q + COUNT_W'(copy_n);
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the current command and the output beat.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= emit_res;
    end
    unique case (state_q)
      ST_HEAD: begin
        op_q   <= entry_i.op;
        want_q <= entry_i.want;
      end
      ST_SIL: begin
        dlen_q <= sil_len;
        zoff_q <= played_q[RING_W-1:0] - sil_len[RING_W-1:0];
      end
      ST_ZERO: begin
        queued_q <= diff_wp;
        if (fire && dlen_q != '0) begin
          dlen_q <= dlen_q - zero_n;
          zoff_q <= zoff_q + zero_n[RING_W-1:0];
        end
      end
      ST_ROOM: begin
        nleft_q <= take_frames;
        ntot_q  <= take_frames;
        src_q   <= '0;
      end
      ST_COPY: begin
        if (fire && nleft_q != '0) begin
          nleft_q <= nleft_q - copy_n;
          src_q   <= src_q + copy_n;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hdl/adrfc_checker.sv
// Port-level checks for the playback ring flow control block, bound to the top level.
module adrfc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [adrfc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [adrfc_pkg::KIND_W-1:0]     m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);
  import adrfc_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // Only the final answer closes a command.
  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == KIND_FINAL)))
    else $error("tlast does not match the final answer");

  // A final answer carries no range.
  a_final_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_FINAL |->
      m_axis_tdata_o[51:0] == '0)
    else $error("final answer carries range fields");

  // A zero-fill range has no source offset, answer or status.
  a_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_ZERO |->
      m_axis_tdata_o[71:35] == '0)
    else $error("zero-fill range carries answer fields");

endmodule

bind audio_dma_ring_flow_control_top adrfc_checker u_adrfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
